/* rtl/core/swrl_pkg.sv */
// Shared types and constants for the sliding window rate limiter.
package swrl_pkg;

  localparam int TICK_W    = 32;
  localparam int OUT_CNT_W = 5;

  localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd1000;

  typedef logic [TICK_W-1:0] tick_t;

  // Control that the top level broadcasts to every cell of the chain.
  typedef struct packed {
    logic  advance;
    logic  shift;
    tick_t window;
  } swrl_ctl_t;

endpackage

/* rtl/core/swrl_req_if.sv */
// Request channel: one tick-stamped request per transfer.
interface swrl_req_if import swrl_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t req_tick;

  modport source (output valid, output req_tick, input ready);
  modport sink (input valid, input req_tick, output ready);
endinterface

/* rtl/core/swrl_res_if.sv */
// Result channel: admission decision and in-window count per transfer.
interface swrl_res_if import swrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 allowed;
  logic [OUT_CNT_W-1:0] in_window_count;

  modport source (output valid, output allowed, output in_window_count, input ready);
  modport sink (input valid, input allowed, input in_window_count, output ready);
endinterface

/* rtl/core/swrl_cell.sv */
// One cell of the chain: holds one recorded tick time and counts it for a passing request.
module swrl_cell import swrl_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  swrl_ctl_t        ctl,
  input  logic [CNT_W-1:0] fill,
  input  logic             tok_vld_in,
  input  tick_t            tok_now_in,
  input  logic [CNT_W-1:0] tok_cnt_in,
  output logic             tok_vld_out,
  output tick_t            tok_now_out,
  output logic [CNT_W-1:0] tok_cnt_out,
  input  tick_t            time_in,
  output tick_t            time_out
);

  logic             tok_vld_r;
  tick_t            tok_now_r;
  logic [CNT_W-1:0] tok_cnt_r;
  tick_t            time_r;
  tick_t            age;
  logic             hit;
  logic [CNT_W-1:0] tok_cnt_nxt;

  // Only entries below the fill level hold a recorded time.
  assign age         = tok_now_in - time_r;
  assign hit         = (fill > CNT_W'(IDX)) && (age < ctl.window);
  assign tok_cnt_nxt = tok_cnt_in + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else if (ctl.advance) begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      tok_now_r <= tok_now_in;
      tok_cnt_r <= tok_cnt_nxt;
    end
    // An accepted request moves every recorded time one cell down the row.
    if (ctl.shift) begin
      time_r <= time_in;
    end
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_now_out = tok_now_r;
  assign tok_cnt_out = tok_cnt_r;
  assign time_out    = time_r;

endmodule

/* rtl/core/sliding_window_rate_limiter.sv */
// Top level of the sliding window log rate limiter.
//
//   channel  direction  payload                         transfer when
//   in_ch    in         req_tick[31:0]                  valid && ready
//   out_ch   out        allowed, in_window_count[4:0]   valid && ready
//   cfg      in         cfg_wr_data[31:0] window_ticks  cfg_wr_en
//
// A request walks the row of MAX_ACCEPTED cells, one cell per cycle while the
// row is not stalled, and its result is registered as it leaves the last cell.
// No new request is taken until that result is registered. Reset clears the
// fill level, the request token and the output valid; the window returns to
// 1000 ticks. A request that reaches the end while the previous result is
// still held waits in the last cell until it is taken.
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int MAX_ACCEPTED = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  swrl_req_if.sink    in_ch,
  swrl_res_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  tick_t       cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_ACCEPTED + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACCEPTED);

  tick_t                window_r;
  logic [CNT_W-1:0]     fill_r;
  logic                 busy_r;
  logic                 out_valid_r;
  logic                 out_allowed_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic             tok_vld [0:MAX_ACCEPTED];
  tick_t            tok_now [0:MAX_ACCEPTED];
  logic [CNT_W-1:0] tok_cnt [0:MAX_ACCEPTED];
  tick_t            time_w  [0:MAX_ACCEPTED-1];

  swrl_ctl_t ctl;
  logic      in_xfer;
  logic      fin;
  logic      done;
  logic      allowed;

  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && !busy_r;

  assign fin     = tok_vld[MAX_ACCEPTED];
  assign done    = fin && (!out_valid_r || out_ch.ready);
  assign allowed = tok_cnt[MAX_ACCEPTED] < CNT_MAX;

  assign ctl.advance = !fin || done;
  assign ctl.shift   = done && allowed;
  assign ctl.window  = window_r;

  assign tok_vld[0] = in_xfer;
  assign tok_now[0] = in_ch.req_tick;
  assign tok_cnt[0] = '0;

  for (genvar k = 0; k < MAX_ACCEPTED; k++) begin : g_cell
    tick_t time_in;
    if (k == 0) begin : g_head
      assign time_in = tok_now[MAX_ACCEPTED];
    end else begin : g_body
      assign time_in = time_w[k-1];
    end

    swrl_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .fill        (fill_r),
      .tok_vld_in  (tok_vld[k]),
      .tok_now_in  (tok_now[k]),
      .tok_cnt_in  (tok_cnt[k]),
      .tok_vld_out (tok_vld[k+1]),
      .tok_now_out (tok_now[k+1]),
      .tok_cnt_out (tok_cnt[k+1]),
      .time_in     (time_in),
      .time_out    (time_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (ctl.shift && (fill_r != CNT_MAX)) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_allowed_r <= allowed;
      out_count_r   <= OUT_CNT_W'(tok_cnt[MAX_ACCEPTED]);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.allowed         = out_allowed_r;
  assign out_ch.in_window_count = out_count_r;

endmodule
